// ===== hw/rtl/fqms_pkg.sv =====
// fqms_pkg: command and status codes, controller states and the per-cell
// control bundle for the fifo queue with membership search
// depends on nothing

package fqms_pkg;

   // command codes on req_command
   localparam logic [1:0] CMD_ENQUEUE  = 2'd0;
   localparam logic [1:0] CMD_DEQUEUE  = 2'd1;
   localparam logic [1:0] CMD_CONTAINS = 2'd2;

   // status codes on rsp_status
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   // fixed port widths
   localparam int unsigned CMD_W   = 2;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 5;

   // controller states
   typedef enum logic [0:0] {
      S_IDLE,
      S_SEARCH
   } state_type;

   // control handed from the controller to one cell
   typedef struct packed {
      logic shift_en;   // take the neighbour's word (dequeue)
      logic load_en;    // take the new word (enqueue at this slot)
      logic occupied;   // slot holds a live entry
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/fqms_cell.sv =====
// fqms_cell: one storage slot of the queue chain with its compare stage
// depends on fqms_pkg

module fqms_cell
   import fqms_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] load_word,
   input  logic [DATA_WIDTH-1:0] next_word,
   input  logic [DATA_WIDTH-1:0] key,
   input  logic                  token_in,
   output logic [DATA_WIDTH-1:0] word_out,
   output logic                  token_out
);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;
   logic                  token_ff;
   logic                  token_in_next;
   logic                  match;

   // word select: shift from neighbour, load new word, or hold
   always_comb begin
      if (ctrl.shift_en) begin
         word_in = next_word;
      end else if (ctrl.load_en) begin
         word_in = load_word;
      end else begin
         word_in = word_ff;
      end
   end

   // local compare, folded into the search flag passed down the chain
   assign match         = ctrl.occupied && (word_ff == key);
   assign token_in_next = token_in | match;

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      token_ff <= token_in_next;
   end

   assign word_out  = word_ff;
   assign token_out = token_ff;

endmodule

// ===== hw/rtl/fifo_queue_with_membership_search_core.sv =====
// fifo_queue_with_membership_search_core: top level, controller plus a chain
// of fqms_cell slots; oldest entry sits in cell 0
// depends on fqms_pkg and fqms_cell
//
//  channel   ports                                   beat taken when
//  -------   -------------------------------------   ------------------------
//  request   start, busy, req_command, req_value     start high, busy low
//  result    rsp_valid, rsp_status, rsp_data_out,    rsp_valid high (one
//            rsp_found, rsp_count, rsp_queue_empty   cycle, no back-pressure)
//
// enqueue, dequeue and unused codes: result strobed the next cycle
// and the next request can be taken in that same cycle
// contains: busy while the match flag walks the cell chain one cell per cycle,
// so the chain length sets how long busy lasts
// synchronous reset empties the queue; stored words are not cleared
// results are strobed for exactly one cycle and cannot be held off

module fifo_queue_with_membership_search_core
   import fqms_pkg::*;
#(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [VALUE_W-1:0] rsp_data_out,
   output logic               rsp_found,
   output logic [COUNT_W-1:0] rsp_count,
   output logic               rsp_queue_empty
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      search_cnt_ff, search_cnt_in;
   logic [DATA_WIDTH-1:0] key_ff;
   logic                  accept;
   logic                  enq_ok;
   logic                  deq_ok;
   logic                  search_done;
   logic                  searching;

   logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
   logic [DATA_WIDTH-1:0]         new_word;
   logic [DATA_WIDTH+VALUE_W-1:0] head_ext;
   logic [CNT_W+COUNT_W-1:0]      count_ext;

   cell_ctrl_type         ctrl   [DEPTH];
   logic [DATA_WIDTH-1:0] words  [DEPTH];
   logic [DATA_WIDTH-1:0] nexts  [DEPTH];
   logic                  tok_in [DEPTH];
   logic                  tok_out[DEPTH];

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [VALUE_W-1:0] rsp_data_ff;
   logic               rsp_found_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_empty_ff;

   // input word cut or zero-extended to the stored width
   assign value_ext = (DATA_WIDTH + VALUE_W)'(req_value);
   assign new_word  = value_ext[DATA_WIDTH-1:0];
   assign head_ext  = (DATA_WIDTH + VALUE_W)'(words[0]);

   assign accept = start && !busy;
   assign enq_ok = accept && (req_command == CMD_ENQUEUE) && (count_ff != CNT_W'(DEPTH));
   assign deq_ok = accept && (req_command == CMD_DEQUEUE) && (count_ff != '0);

   // occupancy after this beat
   always_comb begin
      if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_ok) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_command == CMD_CONTAINS)) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (search_cnt_ff == CNT_W'(DEPTH)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // controller outputs
   always_comb begin
      case (state_ff)
         S_IDLE: begin
            searching   = 1'b0;
            search_done = 1'b0;
         end
         S_SEARCH: begin
            searching   = 1'b1;
            search_done = (search_cnt_ff == CNT_W'(DEPTH));
         end
         default: begin
            searching   = 1'b0;
            search_done = 1'b0;
         end
      endcase
   end

   assign busy = searching;

   // search sweep counter
   always_comb begin
      if (searching) begin
         search_cnt_in = search_cnt_ff + CNT_W'(1);
      end else begin
         search_cnt_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         search_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         search_cnt_ff <= search_cnt_in;
         rsp_valid_ff  <= (accept && (req_command != CMD_CONTAINS)) || search_done;
      end
   end

   // search key
   always_ff @(posedge clock) begin
      if (accept && (req_command == CMD_CONTAINS)) begin
         key_ff <= new_word;
      end
   end

   // result payload
   assign count_ext = (CNT_W + COUNT_W)'(count_in);

   always_ff @(posedge clock) begin
      if (search_done) begin
         rsp_status_ff <= STAT_OK;
         rsp_data_ff   <= '0;
         rsp_found_ff  <= tok_out[DEPTH-1];
         rsp_count_ff  <= count_ext[COUNT_W-1:0];
         rsp_empty_ff  <= (count_in == '0);
      end else if (accept) begin
         rsp_found_ff <= 1'b0;
         rsp_count_ff <= count_ext[COUNT_W-1:0];
         rsp_empty_ff <= (count_in == '0);
         case (req_command)
            CMD_ENQUEUE: begin
               rsp_status_ff <= enq_ok ? STAT_OK : STAT_FULL;
               rsp_data_ff   <= '0;
            end
            CMD_DEQUEUE: begin
               rsp_status_ff <= deq_ok ? STAT_OK : STAT_EMPTY;
               rsp_data_ff   <= deq_ok ? head_ext[VALUE_W-1:0] : '0;
            end
            default: begin
               rsp_status_ff <= STAT_OK;
               rsp_data_ff   <= '0;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_queue_empty = rsp_empty_ff;

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign ctrl[i].shift_en = deq_ok;
      assign ctrl[i].load_en  = enq_ok && (count_ff == CNT_W'(i));
      assign ctrl[i].occupied = (count_ff > CNT_W'(i));

      if (i == DEPTH - 1) begin : g_last
         assign nexts[i] = words[i];
      end else begin : g_mid
         assign nexts[i] = words[i+1];
      end

      if (i == 0) begin : g_first
         assign tok_in[i] = 1'b0;
      end else begin : g_rest
         assign tok_in[i] = tok_out[i-1];
      end

      fqms_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl[i]),
         .load_word (new_word),
         .next_word (nexts[i]),
         .key       (key_ff),
         .token_in  (tok_in[i]),
         .word_out  (words[i]),
         .token_out (tok_out[i])
      );
   end

`ifndef SYNTH
   // occupancy never passes the number of cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy above depth");

   // no result is strobed while a search is walking the chain
   a_quiet_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> !rsp_valid_ff)
      else $error("result strobed during search");

   // occupancy moves by at most one per beat
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         (count_ff == $past(count_ff)) ||
         (count_ff == $past(count_ff) + CNT_W'(1)) ||
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("occupancy jumped");

   // a change of occupancy always comes with a result beat
   a_count_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |-> rsp_valid_ff)
      else $error("occupancy changed without a result");
`endif

endmodule

// ===== tb/sv/fqms_result_checker.sv =====
`timescale 1ns / 100ps
// fqms_result_checker: watches the request and result channels of the fifo queue
// core, predicts each result beat from its own copy of the queue and compares
// depends on fqms_pkg

module fqms_result_checker
   import fqms_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_status,
   input  logic [VALUE_W-1:0] rsp_data_out,
   input  logic               rsp_found,
   input  logic [COUNT_W-1:0] rsp_count,
   input  logic               rsp_queue_empty,
   output int                 error_count,
   output int                 pending_count
);

   // one result beat as the core presents it
   typedef struct packed {
      logic [1:0]         status;
      logic [VALUE_W-1:0] data_out;
      logic               found;
      logic [COUNT_W-1:0] count;
      logic               queue_empty;
   } queue_result_type;

   // shadow copy of the queue, kept as a circular store
   logic [VALUE_W-1:0] model_words [DEPTH];
   int unsigned        model_head = 0;
   int unsigned        model_tail = 0;
   int unsigned        model_fill = 0;

   queue_result_type awaited_results[$];
   queue_result_type want;
   queue_result_type next_want;
   int               errors = 0;

   // one line per mismatch
   task automatic report_error(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [VALUE_W-1:0] got,
                              input logic [VALUE_W-1:0] exp_val);
      if (got !== exp_val) begin
         report_error($sformatf("%s got 0x%08h, predicted 0x%08h", name, got, exp_val));
      end
   endtask

   // apply one command to the shadow queue and work out its result beat
   task automatic apply_queue_op(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] word,
                                 output queue_result_type res);
      res        = '0;
      res.status = STAT_OK;
      case (op)
         CMD_ENQUEUE: begin
            if (model_fill >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               model_words[model_tail] = word;
               model_tail = (model_tail + 1) % DEPTH;
               model_fill++;
            end
         end
         CMD_DEQUEUE: begin
            if (model_fill == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.data_out = model_words[model_head];
               model_head = (model_head + 1) % DEPTH;
               model_fill--;
            end
         end
         CMD_CONTAINS: begin
            // only live entries count, stale words past the tail do not
            for (int i = 0; i < model_fill; i++) begin
               if (model_words[(model_head + i) % DEPTH] == word) begin
                  res.found = 1'b1;
               end
            end
         end
         default: ;
      endcase
      res.count       = COUNT_W'(model_fill);
      res.queue_empty = (model_fill == 0);
   endtask

   // result beat is matched first, then any request beat of the same edge is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (awaited_results.size() == 0) begin
               report_error($sformatf("result beat with nothing awaited, status %0d",
                                      rsp_status));
            end else begin
               want = awaited_results.pop_front();
               check_field("status", VALUE_W'(rsp_status), VALUE_W'(want.status));
               check_field("data_out", rsp_data_out, want.data_out);
               check_field("found", VALUE_W'(rsp_found), VALUE_W'(want.found));
               check_field("count", VALUE_W'(rsp_count), VALUE_W'(want.count));
               check_field("queue_empty", VALUE_W'(rsp_queue_empty),
                           VALUE_W'(want.queue_empty));
            end
         end
         if (start && !busy) begin
            apply_queue_op(req_command, req_value, next_want);
            awaited_results.push_back(next_want);
         end
      end
      pending_count <= awaited_results.size();
      error_count   <= errors;
   end

endmodule

// ===== tb/sv/fifo_queue_with_membership_search_core_tb.sv =====
`timescale 1ns / 100ps
// fifo_queue_with_membership_search_core_tb: stimulus and verdict for the fifo
// queue core; directed beats then phased random traffic with random gaps
// depends on fqms_pkg, fqms_result_checker and fifo_queue_with_membership_search_core

module fifo_queue_with_membership_search_core_tb
   import fqms_pkg::*;
();

   localparam int unsigned     DEPTH          = 16;
   localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
   localparam int              RANDOM_ITEMS   = 1450;
   localparam int              SETTLE_CYCLES  = DEPTH + 8;
   localparam int              WATCHDOG_LIMIT = 400;

   localparam int PHASE_FILL     = 0;
   localparam int PHASE_DRAIN    = 1;
   localparam int PHASE_BALANCED = 2;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [CMD_W-1:0]   req_command;
   logic [VALUE_W-1:0] req_value;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [VALUE_W-1:0] rsp_data_out;
   logic               rsp_found;
   logic [COUNT_W-1:0] rsp_count;
   logic               rsp_queue_empty;

   int error_count;
   int pending_count;
   int idle_cycles = 0;

   // words recently enqueued, so searches hit live and stale entries
   logic [VALUE_W-1:0] recent_words [DEPTH];
   int                 recent_pos = 0;

   fifo_queue_with_membership_search_core #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (32)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found       (rsp_found),
      .rsp_count       (rsp_count),
      .rsp_queue_empty (rsp_queue_empty)
   );

   fqms_result_checker #(
      .DEPTH (DEPTH)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found       (rsp_found),
      .rsp_count       (rsp_count),
      .rsp_queue_empty (rsp_queue_empty),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("** fifo_queue_with_membership_search_core: FAILED **");
      $finish;
   end

   // drive one request beat, hold it until taken, then idle for gap cycles
   task automatic send_beat(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] word,
                            input int gap);
      start       <= 1'b1;
      req_command <= op;
      req_value   <= word;
      if (op == CMD_ENQUEUE) begin
         recent_words[recent_pos] = word;
         recent_pos = (recent_pos + 1) % DEPTH;
      end
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every awaited result beat has come back
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [VALUE_W-1:0] pick_word(input bit for_search);
      int r;
      r = $urandom_range(0, 99);
      if (for_search && r < 40) begin
         return recent_words[$urandom_range(0, DEPTH - 1)];
      end else if (r < 60) begin
         return VALUE_W'($urandom_range(0, 7));
      end else if (r < 70) begin
         return ($urandom_range(0, 1) != 0) ? '1 : '0;
      end else begin
         return $urandom;
      end
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(input int kind);
      int r;
      int enq_lim;
      int deq_lim;
      r = $urandom_range(0, 99);
      case (kind)
         PHASE_FILL: begin
            enq_lim = 60;
            deq_lim = 75;
         end
         PHASE_DRAIN: begin
            enq_lim = 15;
            deq_lim = 70;
         end
         default: begin
            enq_lim = 35;
            deq_lim = 65;
         end
      endcase
      if (r < enq_lim) return CMD_ENQUEUE;
      if (r < deq_lim) return CMD_DEQUEUE;
      if (r < 95) return CMD_CONTAINS;
      return CMD_UNUSED;
   endfunction

   initial begin
      int               sent;
      int               phase_len;
      int               phase_kind;
      int               gap_mode;
      int               gap;
      int               phase_no;
      logic [CMD_W-1:0] op;

      sent     = 0;
      phase_no = 0;
      for (int i = 0; i < DEPTH; i++) begin
         recent_words[i] = '0;
      end
      reset       <= 1'b1;
      start       <= 1'b0;
      req_command <= CMD_ENQUEUE;
      req_value   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queue cases, extremes, duplicates, hits and misses
      send_beat(CMD_DEQUEUE, 32'h1234_5678, 0);
      send_beat(CMD_CONTAINS, 32'h0000_0000, 0);
      send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 0);
      send_beat(CMD_ENQUEUE, 32'h0000_0000, 0);
      send_beat(CMD_ENQUEUE, 32'hFFFF_FFFF, 0);
      send_beat(CMD_ENQUEUE, 32'h0000_0000, 0);
      send_beat(CMD_CONTAINS, 32'h0000_0000, 0);
      send_beat(CMD_CONTAINS, 32'hFFFF_FFFF, 0);
      send_beat(CMD_CONTAINS, 32'h0000_0001, 0);
      send_beat(CMD_UNUSED, 32'h0000_0000, 0);
      send_beat(CMD_DEQUEUE, 32'hFFFF_FFFF, 0);
      send_beat(CMD_CONTAINS, 32'hFFFF_FFFF, 0);
      send_beat(CMD_DEQUEUE, 32'h0000_0000, 0);
      send_beat(CMD_DEQUEUE, 32'h0000_0000, 0);
      // stale words are left behind in the store but must not match
      send_beat(CMD_CONTAINS, 32'hFFFF_FFFF, 0);
      send_beat(CMD_CONTAINS, 32'h0000_0000, 0);
      send_beat(CMD_DEQUEUE, 32'hA5A5_5A5A, 0);
      send_beat(CMD_ENQUEUE, 32'h8000_0001, 3);
      send_beat(CMD_CONTAINS, 32'h8000_0001, 5);
      send_beat(CMD_DEQUEUE, 32'h0000_0000, 0);
      wait_drained();

      // random phases, each leaning towards filling, draining or neither
      while (sent < RANDOM_ITEMS) begin
         phase_len  = $urandom_range(30, 90);
         phase_kind = (phase_no == 0) ? PHASE_FILL : $urandom_range(0, 2);
         gap_mode   = $urandom_range(0, 2);
         for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
            op = pick_command(phase_kind);
            case (gap_mode)
               0:       gap = 0;
               1:       gap = $urandom_range(0, 19);
               default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            endcase
            send_beat(op, pick_word(op == CMD_CONTAINS), gap);
            sent++;
         end
         if (phase_no == 0 || $urandom_range(0, 2) == 0) begin
            wait_drained();
         end
         phase_no++;
      end

      // let the last beats come back, then allow for a final search
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("** fifo_queue_with_membership_search_core: PASSED **");
      end else begin
         $display("** fifo_queue_with_membership_search_core: FAILED **");
      end
      $finish;
   end

endmodule
